### sv/chm_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash map package
// Shared constants, opcodes, status codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int MaxBucketsDef  = 256;
    localparam int PoolEntriesDef = 1024;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 64;
    localparam int CFG_W     = 9;
    localparam int COUNT_W   = 11;

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_ZERO_KEY = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture input item
        logic mod_start;   // start bucket index reduction
        logic head_rd;     // read bucket head
        logic head_take;   // take head read data as current
        logic pool_rd;     // read pool entry at current
        logic step;        // advance prev/cur along chain
        logic mark_found;  // current entry matches key
        logic mark_full;   // no entry left for a new key
        logic do_set_upd;  // overwrite value of found entry
        logic do_alloc;    // push new entry at chain head
        logic free_rd;     // read next of free list head
        logic do_unlink;   // unlink found entry
        logic do_free;     // push found entry on free list
        logic do_get;      // capture value of found entry
        logic clr_wr;      // clear bucket head row
        logic out_load;    // load result register
    } chm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic       key_zero;
        logic [1:0] op;
        logic       mod_done;
        logic       cur_nil;
        logic       key_match;
        logic       steps_max;
        logic       found;
        logic       free_avail;
        logic       fresh_avail;
        logic       clr_done;
    } chm_sts_t;

endpackage

### sv/chm_ctrl.sv
// ----------------------------------------------------------------------------
// Chained hash map controller
// Sequences bucket clearing, index reduction, chain walk and update.
// ----------------------------------------------------------------------------
module chm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              out_busy,
    input  chm_pkg::chm_sts_t sts,
    output chm_pkg::chm_cmd_t cmd
);
    import chm_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_HEADW = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_ACT   = 4'd7;
    localparam logic [3:0] S_FREE  = 4'd8;
    localparam logic [3:0] S_ALLOC = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_GETW  = 4'd11;
    localparam logic [3:0] S_REL   = 4'd12;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_CLEAR;
        else          state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load      = 1'b1;
                    cmd.mod_start = 1'b1;
                    state_next    = S_MOD;
                end
            end
            S_MOD: begin
                if (sts.key_zero || sts.op == OP_NOP) begin
                    state_next = S_OUT;
                end else if (sts.mod_done) begin
                    cmd.head_rd = 1'b1;
                    state_next  = S_HEAD;
                end
            end
            S_HEAD: begin
                cmd.head_take = 1'b1;
                state_next    = S_HEADW;
            end
            S_HEADW: begin
                if (sts.cur_nil) begin
                    state_next = S_ACT;
                end else begin
                    cmd.pool_rd = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD: state_next = S_CMP;
            S_CMP: begin
                if (sts.key_match) begin
                    cmd.mark_found = 1'b1;
                    state_next     = S_ACT;
                end else if (sts.steps_max) begin
                    state_next = S_ACT;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_HEADW;
                end
            end
            S_ACT: begin
                state_next = S_OUT;
                case (sts.op)
                    OP_SET: begin
                        if (sts.found) begin
                            cmd.do_set_upd = 1'b1;
                        end else if (sts.free_avail) begin
                            cmd.free_rd = 1'b1;
                            state_next  = S_FREE;
                        end else if (sts.fresh_avail) begin
                            state_next = S_ALLOC;
                        end else begin
                            cmd.mark_full = 1'b1;
                        end
                    end
                    OP_GET: begin
                        if (sts.found) begin
                            cmd.pool_rd = 1'b1;
                            state_next  = S_GETW;
                        end
                    end
                    OP_REMOVE: begin
                        if (sts.found) begin
                            cmd.do_unlink = 1'b1;
                            state_next    = S_REL;
                        end
                    end
                    default: ;
                endcase
            end
            S_FREE: state_next = S_ALLOC;
            S_ALLOC: begin
                cmd.do_alloc = 1'b1;
                state_next   = S_OUT;
            end
            S_GETW: begin
                cmd.do_get = 1'b1;
                state_next = S_OUT;
            end
            // Return the unlinked entry to the free list
            S_REL: begin
                cmd.do_free = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### sv/chm_datapath.sv
// ----------------------------------------------------------------------------
// Chained hash map datapath
// Bucket head and pool memories, serial index reduction, chain pointers.
// ----------------------------------------------------------------------------
module chm_datapath #(
    parameter int MAX_BUCKETS  = chm_pkg::MaxBucketsDef,
    parameter int POOL_ENTRIES = chm_pkg::PoolEntriesDef
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  chm_pkg::chm_cmd_t           cmd,
    output chm_pkg::chm_sts_t           sts,
    input  logic [1:0]                  in_opcode,
    input  logic [chm_pkg::KEY_W-1:0]   in_key,
    input  logic [chm_pkg::VAL_W-1:0]   in_value,
    input  logic [chm_pkg::CFG_W-1:0]   bucket_count,
    output logic                        res_found,
    output logic [chm_pkg::VAL_W-1:0]   res_value,
    output logic [1:0]                  res_status,
    output logic [chm_pkg::COUNT_W-1:0] res_count
);
    import chm_pkg::*;

    localparam int PW = $clog2(POOL_ENTRIES + 1);  // pointer with nil
    localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int MW = $clog2(MAX_BUCKETS + 1);
    localparam int SW = 64;
    localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

    // Memories
    logic [PW-1:0]    head_mem [MAX_BUCKETS];
    logic [KEY_W-1:0] key_mem  [POOL_ENTRIES];
    logic [VAL_W-1:0] val_mem  [POOL_ENTRIES];
    logic [PW-1:0]    next_mem [POOL_ENTRIES];

    logic [1:0]       op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [BW-1:0]    bkt_reg;
    logic [PW-1:0]    cur_reg, prev_reg, head_q, next_q, free_reg, fresh_reg;
    logic [KEY_W-1:0] key_q;
    logic [VAL_W-1:0] val_q;
    logic [PW-1:0]    steps_reg;
    logic             found_reg;
    logic             full_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [BW:0]      clr_reg;
    logic [VAL_W-1:0] vout_reg;

    // Serial restoring remainder: one dividend bit per cycle
    logic [SW-1:0]    div_reg;
    logic [MW:0]      rem_reg;
    logic [6:0]       bit_reg;
    logic             mod_busy_reg;
    logic [MW-1:0]    modulus;
    logic [MW:0]      rem_shift;

    always_comb begin
        if (bucket_count == '0)                        modulus = MW'(1);
        else if (32'(bucket_count) > 32'(MAX_BUCKETS)) modulus = MW'(MAX_BUCKETS);
        else                                           modulus = MW'(bucket_count);
    end

    assign rem_shift = {rem_reg[MW-1:0], div_reg[SW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_busy_reg <= 1'b0;
        end else if (cmd.mod_start) begin
            mod_busy_reg <= 1'b1;
            div_reg      <= {{32{in_key[KEY_W-1]}}, in_key};
            rem_reg      <= '0;
            bit_reg      <= '0;
        end else if (mod_busy_reg) begin
            div_reg <= {div_reg[SW-2:0], 1'b0};
            if (rem_shift >= {1'b0, modulus}) rem_reg <= rem_shift - {1'b0, modulus};
            else                              rem_reg <= rem_shift;
            bit_reg <= bit_reg + 7'd1;
            if (bit_reg == 7'd63) mod_busy_reg <= 1'b0;
        end
    end

    // Capture item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_opcode;
            key_reg <= in_key;
            val_reg <= in_value;
        end
    end

    // Bucket head memory: clear sweep, read, write
    always_ff @(posedge aclk) begin
        if (cmd.clr_wr && !clr_reg[BW]) head_mem[clr_reg[BW-1:0]] <= NIL;
        if (cmd.do_alloc) head_mem[bkt_reg] <= (free_reg != NIL) ? free_reg : fresh_reg;
        if (cmd.do_unlink && prev_reg == NIL) head_mem[bkt_reg] <= next_q;
        if (cmd.head_rd) head_q <= head_mem[BW'(rem_reg)];
    end

    // Clear sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn)                   clr_reg <= '0;
        else if (cmd.clr_wr && !clr_reg[BW] && 32'(clr_reg) < 32'(MAX_BUCKETS))
            clr_reg <= clr_reg + 1'b1;
    end

    // Pool memories
    logic [AW-1:0] rd_addr, alloc_addr, nfree_addr;
    assign rd_addr    = cur_reg[AW-1:0];
    assign alloc_addr = (free_reg != NIL) ? free_reg[AW-1:0] : fresh_reg[AW-1:0];
    assign nfree_addr = free_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.pool_rd) begin
            key_q  <= key_mem[rd_addr];
            val_q  <= val_mem[rd_addr];
        end
        if (cmd.pool_rd) next_q <= next_mem[rd_addr];
        else if (cmd.free_rd) next_q <= next_mem[nfree_addr];
        if (cmd.do_alloc) begin
            key_mem[alloc_addr] <= key_reg;
            val_mem[alloc_addr] <= val_reg;
        end
        if (cmd.do_set_upd) val_mem[rd_addr] <= val_reg;
        // One link write per cycle: new entry, predecessor, or freed entry
        if (cmd.do_alloc) next_mem[alloc_addr] <= head_q;
        else if (cmd.do_unlink && prev_reg != NIL) next_mem[prev_reg[AW-1:0]] <= next_q;
        else if (cmd.do_free) next_mem[rd_addr] <= free_reg;
    end

    // Chain pointers, free list and counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg  <= NIL;
            fresh_reg <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.load) found_reg <= 1'b0;
            if (cmd.mark_found) found_reg <= 1'b1;
            if (cmd.do_alloc) begin
                if (free_reg != NIL) free_reg <= next_q;
                else                 fresh_reg <= fresh_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.do_free) begin
                free_reg <= cur_reg;
                if (count_reg != '0) count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.head_rd) bkt_reg <= BW'(rem_reg);
        if (cmd.head_take) begin
            cur_reg   <= head_q;
            prev_reg  <= NIL;
            steps_reg <= '0;
        end else if (cmd.step) begin
            prev_reg  <= cur_reg;
            cur_reg   <= next_q;
            steps_reg <= steps_reg + 1'b1;
        end
    end

    // Result collection
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            vout_reg <= '0;
        end else if (cmd.do_get) begin
            vout_reg <= val_q;
        end
    end

    // Pool full flag, set when a new key finds no entry
    always_ff @(posedge aclk) begin
        if (cmd.load)           full_reg <= 1'b0;
        else if (cmd.mark_full) full_reg <= 1'b1;
    end

    assign sts.key_zero    = (key_reg == '0);
    assign sts.op          = op_reg;
    assign sts.mod_done    = !mod_busy_reg;
    assign sts.cur_nil     = (cur_reg >= NIL);
    assign sts.key_match   = (key_q == key_reg);
    assign sts.steps_max   = (steps_reg + 1'b1 >= NIL);
    assign sts.found       = found_reg;
    assign sts.free_avail  = (free_reg != NIL);
    assign sts.fresh_avail = (fresh_reg != NIL);
    assign sts.clr_done    = clr_reg[BW] || 32'(clr_reg) >= 32'(MAX_BUCKETS) - 1;

    assign res_found  = found_reg && key_reg != '0 && op_reg != OP_NOP;
    assign res_value  = (op_reg == OP_GET) ? vout_reg : '0;
    assign res_status = (key_reg == '0) ? ST_ZERO_KEY : (full_reg ? ST_FULL : ST_OK);
    assign res_count  = count_reg;

endmodule

### sv/chained_hash_map_int_key_core.sv
// Flow: a zero key or the unused opcode goes straight to the result; otherwise a
//   serial bucket index reduction is done, then a pool read and a key compare
//   for each chain entry visited.
// Throughput: one item at a time; next item taken the cycle after the result is loaded.
// Reset: synchronous active-low; afterwards a sweep clears every bucket head
//   before the first item is accepted.
// ----------------------------------------------------------------------------
// Chained hash map core
// Set/get/remove on a 32-bit key map with separate chaining in a fixed pool.
// ----------------------------------------------------------------------------
module chained_hash_map_int_key_core #(
    parameter int MAX_BUCKETS  = chm_pkg::MaxBucketsDef,
    parameter int POOL_ENTRIES = chm_pkg::PoolEntriesDef
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // opcode[1:0], key[33:2], value[97:34], zero pad
    input  logic          m_tready,
    output logic          m_tvalid,
    output logic [79:0]   m_tdata,   // found[0], value_out[64:1], holds_nonzero[65],
                                     // status[67:66], entry_count_out[78:68], pad
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [8:0]    cfg_data
);
    import chm_pkg::*;

    chm_cmd_t cmd;
    chm_sts_t sts;

    logic [CFG_W-1:0]   bcount_reg;
    logic               r_found;
    logic [VAL_W-1:0]   r_value;
    logic [1:0]         r_status;
    logic [COUNT_W-1:0] r_count;
    logic               m_valid_reg;
    logic [79:0]        m_data_reg;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn)       bcount_reg <= CFG_W'(256);
        else if (cfg_valid) bcount_reg <= cfg_data;
    end

    chm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_busy (m_valid_reg && !m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    chm_datapath #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_opcode    (s_tdata[1:0]),
        .in_key       (s_tdata[33:2]),
        .in_value     (s_tdata[97:34]),
        .bucket_count (bcount_reg),
        .res_found    (r_found),
        .res_value    (r_value),
        .res_status   (r_status),
        .res_count    (r_count)
    );

    // Output register: hold until transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load)
            m_data_reg <= {1'b0, r_count, r_status, (r_value != '0), r_value, r_found};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
